// ===== rtl/core/acm_pkg.sv =====
package acm_pkg;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_DEL = 8'h7F;

  localparam int PREFIX_LEN = 5;
  localparam int NAME_COUNT = 4;

  localparam logic [7:0] NAME_HEAD [3] = '{8'h41, 8'h54, 8'h2B};
  localparam logic [7:0] NAME_TAIL [NAME_COUNT] = '{8'h68, 8'h76, 8'h72, 8'h74};

  typedef enum logic [2:0] {
    CMD_HELP    = 3'd0,
    CMD_VERSION = 3'd1,
    CMD_RESET   = 3'd2,
    CMD_TASK    = 3'd3,
    CMD_UNKNOWN = 3'd4
  } cmd_code_t;

  typedef struct packed {
    logic       func;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    cmd_code_t cmd_code;
    logic      ended_by_full;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t res;
  } step_result_t;

endpackage

// ===== rtl/core/acm_chan_if.sv =====
interface acm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/acm_line_core.sv =====
module acm_line_core #(
  parameter int LINE_DEPTH = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  acm_pkg::in_item_t     item,
  output acm_pkg::step_result_t result
);
  import acm_pkg::*;

  localparam int COUNT_W = $clog2(LINE_DEPTH + 1);

  logic               waiting_mode;
  logic [COUNT_W-1:0] fill_count;
  logic [7:0]         prefix [PREFIX_LEN];

  logic      is_cr;
  logic      is_del;
  logic      full;
  logic      line_end;
  logic      head_ok;
  cmd_code_t code;

  assign is_cr  = item.char_in == CHAR_CR;
  assign is_del = item.char_in == CHAR_DEL;
  assign full   = fill_count == COUNT_W'(LINE_DEPTH);
  assign line_end = !waiting_mode && !item.func && (is_cr || full);

  // only the first five bytes decide a match: four nonzero, then a zero
  always_comb begin
    head_ok = (prefix[0] == NAME_HEAD[0]) && (prefix[1] == NAME_HEAD[1]) &&
              (prefix[2] == NAME_HEAD[2]) && (prefix[4] == 8'h00);
    code = CMD_UNKNOWN;
    for (int k = NAME_COUNT - 1; k >= 0; k--) begin
      if (head_ok && prefix[3] == NAME_TAIL[k]) begin
        code = cmd_code_t'(k);
      end
    end
  end

  assign result.emit              = line_end;
  assign result.res.cmd_code      = code;
  assign result.res.ended_by_full = full && !is_cr;

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_mode <= 1'b0;
      fill_count   <= '0;
      for (int i = 0; i < PREFIX_LEN; i++) begin
        prefix[i] <= 8'h00;
      end
    end else if (step) begin
      if (waiting_mode) begin
        if (item.func) begin
          waiting_mode <= 1'b0;
        end
      end else if (!item.func) begin
        if (line_end) begin
          fill_count <= '0;
          for (int i = 0; i < PREFIX_LEN; i++) begin
            prefix[i] <= 8'h00;
          end
          if (code == CMD_TASK) begin
            waiting_mode <= 1'b1;
          end
        end else if (is_del) begin
          if (fill_count != '0) begin
            fill_count <= fill_count - 1'b1;
            for (int i = 0; i < PREFIX_LEN; i++) begin
              if (fill_count == COUNT_W'(i + 1)) begin
                prefix[i] <= 8'h00;
              end
            end
          end
        end else begin
          fill_count <= fill_count + 1'b1;
          for (int i = 0; i < PREFIX_LEN; i++) begin
            if (fill_count == COUNT_W'(i)) begin
              prefix[i] <= item.char_in;
            end
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/at_command_line_matcher.sv =====
// path: the input beat that ends the line is held in the input register, then its result beat in the result register
// throughput: one input beat per cycle; a held result stalls input only once the
//   input register is also occupied
// reset: synchronous, active high; clears the line store, fill count, waiting mode
//   and the valid flags of both pipeline registers
module at_command_line_matcher #(
  parameter int LINE_DEPTH = 10
) (
  input logic       clk,
  input logic       rst,
  acm_chan_if.sink   rx,
  acm_chan_if.source result
);
  import acm_pkg::*;

  logic         s1_valid;
  in_item_t     s1_item;
  logic         out_free;
  logic         advance;
  step_result_t core_res;
  logic         res_valid;
  out_item_t    res_item;

  assign out_free = !res_valid || result.ready;
  assign advance  = s1_valid && out_free;
  assign rx.ready = !s1_valid || out_free;

  assign result.valid   = res_valid;
  assign result.payload = res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready) begin
      s1_item <= rx.payload;
    end
  end

  acm_line_core #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= advance && core_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res.emit) begin
      res_item <= core_res.res;
    end
  end

  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(advance && core_res.emit))
    else $error("result beat without a line end");

  a_ready_event_silent: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.func |-> !core_res.emit)
    else $error("ready event produced a result");

  a_end_cause: assert property (@(posedge clk) disable iff (rst)
    advance && core_res.emit |->
      core_res.res.ended_by_full || s1_item.char_in == CHAR_CR)
    else $error("line ended without cr or full store");

endmodule
